[hdl/fcr_pkg.sv]
// ----------------------------------------------------------------------------
// fcr_pkg: shared types and constants for the framed command receiver
// Frame codes, type codes, TLV tags and the controller command/status structs.
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int MAX_PAYLOAD = 128;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

   localparam logic [7:0] SYNC_BYTE    = 8'hA5;
   localparam logic [7:0] TYPE_HANDSHK = 8'h10;
   localparam logic [7:0] TYPE_CONFIG  = 8'h11;
   localparam logic [7:0] TYPE_FLOW_Q  = 8'h20;
   localparam logic [7:0] TYPE_FLOW_I  = 8'h21;

   localparam logic [7:0] TAG_TELEM = 8'h01;
   localparam logic [7:0] TAG_HEART = 8'h02;
   localparam logic [7:0] TAG_PGAIN = 8'h03;
   localparam logic [7:0] TAG_IGAIN = 8'h04;
   localparam logic [7:0] TAG_PIEN  = 8'h05;

   localparam logic [1:0] REPLY_NONE = 2'd0;
   localparam logic [1:0] REPLY_ACK  = 2'd1;
   localparam logic [1:0] REPLY_NACK = 2'd2;
   localparam logic [1:0] REPLY_HACK = 2'd3;

   localparam logic [1:0] FLOW_NONE   = 2'd0;
   localparam logic [1:0] FLOW_QUEUED = 2'd1;
   localparam logic [1:0] FLOW_IMMED  = 2'd2;

   localparam logic [1:0] CSR_HEART = 2'd0;
   localparam logic [1:0] CSR_TELEM = 2'd1;
   localparam logic [1:0] CSR_ACK   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic       take_type;   // latch type byte, seed checksum
      logic       take_seq;
      logic       take_len;
      logic       store_byte;  // write payload byte, fold into checksum
      logic       take_check;  // latch check byte and room
      logic       rd_en;       // issue payload read
      logic [7:0] rd_addr;
      logic       cap_byte;    // capture read data into slot
      logic [1:0] cap_slot;    // byte slot 0..3 of gather word
      logic       cap_tag;     // capture read data as tlv tag
      logic       cap_tlen;    // capture read data as tlv length
      logic       clr_word;
      logic       apply_tlv;   // apply gathered tlv value
      logic       apply_hs;    // load handshake word into heartbeat and telemetry
      logic       hs_ack_byte; // capture byte 4 as ack flag
      logic       finish;      // build result
   } fcr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [7:0] held_length;
      logic [7:0] held_type;
      logic [7:0] byte_count;
      logic       check_ok;
      logic [7:0] tlv_len;
   } fcr_sts_type;

endpackage

[hdl/framed_command_receiver_top.sv]
// ----------------------------------------------------------------------------
// framed_command_receiver_top: framed command receiver
// Parses [A5][type][seq][len][payload][xor] frames and dispatches commands.
// After the check byte of a valid frame the controller walks the payload: the
//   first word for a flow request, that word and byte 4 for a handshake, and
//   each TLV entry for config; then the reply is presented.
// Throughput: one byte per cycle, stalled during the end-of-frame walk,
//   which reads the payload RAM back byte by byte, and while a reply waits.
// Reset: synchronous; defaults return to 1000 / 100 / ack enabled.
// ----------------------------------------------------------------------------
module framed_command_receiver_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // rx_byte
   input  logic          req_tuser,   // queue_has_room
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // reply_kind, reply_seq, frame_type, check_ok, flow_request, flow_value,
   // handshake_done, heartbeat_period_out, telemetry_period_out,
   // prop_gain_bits, integral_gain_bits, loop_enable, zero pad
   output logic [151:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);
   import fcr_pkg::*;

   fcr_cmd_type  cmd;
   fcr_sts_type  sts;
   logic [150:0] result;

   fcr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .rx_byte   (req_tdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fcr_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .rx_byte        (req_tdata),
      .queue_has_room (req_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .result         (result)
   );

   assign rsp_tdata = {1'b0, result};
endmodule

[hdl/fcr_ram.sv]
// ----------------------------------------------------------------------------
// fcr_ram: generic simple dual-port RAM with registered read
// One write and one read per cycle.
// ----------------------------------------------------------------------------
module fcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[hdl/fcr_datapath.sv]
// ----------------------------------------------------------------------------
// fcr_datapath: header registers, payload store, checksum and live settings
// Executes controller commands; holds the result register.
// ----------------------------------------------------------------------------
module fcr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  fcr_pkg::fcr_cmd_type cmd,
   output fcr_pkg::fcr_sts_type sts,
   input  logic [7:0]          rx_byte,
   input  logic                queue_has_room,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output logic [150:0]        result
);
   import fcr_pkg::*;

   logic [7:0]  type_ff, seq_ff, len_ff, cnt_ff, xor_ff, chk_ff, tag_ff, tlen_ff;
   logic        room_ff, ack_ff, pi_ff;
   logic [15:0] hb_ff, tm_ff;
   logic [31:0] pg_ff, ig_ff, word_ff;
   logic [7:0]  rd_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [150:0] res_in;
   logic [1:0]  kind;
   logic [1:0]  freq;
   logic [31:0] fval;
   logic        ok, hs;

   assign rd_addr = cmd.rd_addr[ADDR_W-1:0];

   fcr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.store_byte && (cnt_ff < 8'(MAX_PAYLOAD))),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ok = (xor_ff == chk_ff);
   assign sts.held_length = len_ff;
   assign sts.held_type   = type_ff;
   assign sts.byte_count  = cnt_ff;
   assign sts.check_ok    = ok;
   assign sts.tlv_len     = tlen_ff;

   // decide the reply from held header and check result
   always_comb begin
      kind = REPLY_NONE;
      freq = FLOW_NONE;
      fval = '0;
      hs   = 1'b0;
      if (ok) begin
         if (type_ff == TYPE_HANDSHK) begin
            if (len_ff >= 8'd5) begin
               kind = REPLY_HACK;
               hs   = 1'b1;
            end else if (ack_ff) begin
               kind = REPLY_NACK;
            end
         end else if (type_ff == TYPE_CONFIG) begin
            if (ack_ff) kind = REPLY_ACK;
         end else if (type_ff == TYPE_FLOW_Q || type_ff == TYPE_FLOW_I) begin
            if (len_ff >= 8'd4) begin
               fval = word_ff;
               if (type_ff == TYPE_FLOW_Q) begin
                  freq = FLOW_QUEUED;
                  if (ack_ff) kind = room_ff ? REPLY_ACK : REPLY_NACK;
               end else begin
                  freq = FLOW_IMMED;
                  if (ack_ff) kind = REPLY_ACK;
               end
            end else if (ack_ff) begin
               kind = REPLY_NACK;
            end
         end else if (ack_ff) begin
            kind = REPLY_NACK;
         end
      end else if (ack_ff) begin
         kind = REPLY_NACK;
      end
      res_in = {pi_ff, ig_ff, pg_ff, tm_ff, hb_ff, hs, fval, freq, ok, type_ff,
                seq_ff, kind};
   end

   // header, checksum and gather registers
   always_ff @(posedge clock) begin
      if (cmd.take_type) begin
         type_ff <= rx_byte;
         xor_ff  <= rx_byte;
      end
      if (cmd.take_seq) begin
         seq_ff <= rx_byte;
         xor_ff <= xor_ff ^ rx_byte;
      end
      if (cmd.store_byte) xor_ff <= xor_ff ^ rx_byte;
      if (cmd.take_check) begin
         chk_ff  <= rx_byte;
         room_ff <= queue_has_room;
      end
      if (cmd.clr_word) word_ff <= '0;
      if (cmd.cap_byte) begin
         unique case (cmd.cap_slot)
            2'd0:    word_ff[7:0]   <= rd_data;
            2'd1:    word_ff[15:8]  <= rd_data;
            2'd2:    word_ff[23:16] <= rd_data;
            default: word_ff[31:24] <= rd_data;
         endcase
      end
      if (cmd.cap_tag)  tag_ff  <= rd_data;
      if (cmd.cap_tlen) tlen_ff <= rd_data;
      if (cmd.finish)   result  <= res_in;
   end

   // control-like registers: length, count, live settings
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         cnt_ff <= '0;
         hb_ff <= 16'd1000;
         tm_ff <= 16'd100;
         ack_ff <= 1'b1;
         pg_ff <= '0;
         ig_ff <= '0;
         pi_ff <= 1'b0;
      end else begin
         if (cmd.take_len) begin
            len_ff <= rx_byte;
            cnt_ff <= '0;
         end
         if (cmd.store_byte) cnt_ff <= cnt_ff + 8'd1;
         if (cmd.finish) begin
            len_ff <= '0;
            cnt_ff <= '0;
         end
         if (cmd.apply_hs) begin
            hb_ff <= word_ff[15:0];
            tm_ff <= word_ff[31:16];
         end
         if (cmd.hs_ack_byte) ack_ff <= (rd_data != 8'd0);
         if (cmd.apply_tlv) begin
            if (tag_ff == TAG_TELEM && tlen_ff == 8'd2) tm_ff <= word_ff[15:0];
            if (tag_ff == TAG_HEART && tlen_ff == 8'd2) hb_ff <= word_ff[15:0];
            if (tag_ff == TAG_PGAIN && tlen_ff == 8'd4) pg_ff <= word_ff;
            if (tag_ff == TAG_IGAIN && tlen_ff == 8'd4) ig_ff <= word_ff;
            if (tag_ff == TAG_PIEN && tlen_ff == 8'd1) pi_ff <= (word_ff[7:0] != 8'd0);
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEART: hb_ff  <= csr_wdata;
               CSR_TELEM: tm_ff  <= csr_wdata;
               CSR_ACK:   ack_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // a handshake ack is reported only together with the handshake flag
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) |-> ((result[1:0] == REPLY_HACK) == result[53]))
      else $error("handshake ack and flag disagree");
   // flow value is zero when no flow request is made
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) && (result[20:19] == FLOW_NONE) |-> (result[52:21] == '0))
      else $error("flow value set without a request");
   // payload writes never outrun the declared length
   assert property (@(posedge clock) disable iff (reset)
      cmd.store_byte |-> (cnt_ff < len_ff))
      else $error("payload write past frame length");
endmodule

[hdl/fcr_controller.sv]
// ----------------------------------------------------------------------------
// fcr_controller: frame parser and dispatch sequencer
// Walks the header, payload and check byte, then steps payload reads.
// ----------------------------------------------------------------------------
module fcr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           rx_byte,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fcr_pkg::fcr_cmd_type  cmd,
   input  fcr_pkg::fcr_sts_type  sts
);
   import fcr_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_TYPE  = 4'd1;
   localparam logic [3:0] ST_SEQ   = 4'd2;
   localparam logic [3:0] ST_LEN   = 4'd3;
   localparam logic [3:0] ST_PAY   = 4'd4;
   localparam logic [3:0] ST_CHECK = 4'd5;
   localparam logic [3:0] ST_WORD  = 4'd6;  // read 4 bytes for flow/handshake
   localparam logic [3:0] ST_HACK  = 4'd7;  // read byte 4 for handshake ack flag
   localparam logic [3:0] ST_TAG   = 4'd8;
   localparam logic [3:0] ST_TLEN  = 4'd9;
   localparam logic [3:0] ST_TVAL  = 4'd10;
   localparam logic [3:0] ST_APPLY = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [8:0] pos_ff, pos_in;    // walk position
   logic [2:0] k_ff, k_in;        // read index within group
   logic       pend_ff, pend_in;  // read issued last cycle
   logic       acc;
   logic       is_hs, is_flow;

   assign acc     = in_valid && in_ready;
   assign in_ready = (state_ff <= ST_CHECK);
   assign out_valid = (state_ff == ST_OUT);
   assign is_hs   = (sts.held_type == TYPE_HANDSHK) && (sts.held_length >= 8'd5);
   assign is_flow = (sts.held_type == TYPE_FLOW_Q || sts.held_type == TYPE_FLOW_I)
                    && (sts.held_length >= 8'd4);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      k_in     = k_ff;
      pend_in  = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: if (acc && rx_byte == SYNC_BYTE) state_in = ST_TYPE;
         ST_TYPE: if (acc) begin
            cmd.take_type = 1'b1;
            state_in = ST_SEQ;
         end
         ST_SEQ: if (acc) begin
            cmd.take_seq = 1'b1;
            state_in = ST_LEN;
         end
         ST_LEN: if (acc) begin
            cmd.take_len = 1'b1;
            if (rx_byte == 8'd0) state_in = ST_CHECK;
            else if (rx_byte <= 8'(MAX_PAYLOAD)) state_in = ST_PAY;
            else state_in = ST_IDLE;
         end
         ST_PAY: if (acc) begin
            cmd.store_byte = 1'b1;
            if (sts.byte_count + 8'd1 >= sts.held_length) state_in = ST_CHECK;
         end
         ST_CHECK: if (acc) begin
            cmd.take_check = 1'b1;
            cmd.clr_word   = 1'b1;
            k_in     = '0;
            pos_in   = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // dispatch after check settles
            if (!sts.check_ok) state_in = ST_APPLY;
            else if (is_hs || is_flow) state_in = ST_WORD;
            else if (sts.held_type == TYPE_CONFIG) state_in = ST_TAG;
            else state_in = ST_APPLY;
            k_in = '0;
         end
         ST_WORD: begin
            // issue reads 0..3, capture each byte in the cycle after its read
            if (pend_ff) begin
               cmd.cap_byte = 1'b1;
               cmd.cap_slot = 2'(k_ff - 3'd1);
            end
            if (k_ff < 3'd4) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = 8'(k_ff);
               pend_in = 1'b1;
               k_in    = k_ff + 3'd1;
            end else if (!pend_ff) begin
               cmd.apply_hs = is_hs;
               state_in = is_hs ? ST_HACK : ST_APPLY;
               k_in = '0;
            end
         end
         ST_HACK: begin
            cmd.rd_addr = 8'd4;
            if (k_ff == 3'd0) begin
               k_in = 3'd1;
            end else begin
               cmd.hs_ack_byte = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_TAG: begin
            // need two bytes for tag and length
            cmd.rd_addr = pos_ff[7:0];
            if (pos_ff + 9'd2 > {1'b0, sts.held_length}) begin
               state_in = ST_APPLY;
            end else if (k_ff == 3'd0) begin
               k_in = 3'd1;
            end else begin
               cmd.cap_tag = 1'b1;
               pos_in = pos_ff + 9'd1;
               k_in = '0;
               state_in = ST_TLEN;
            end
         end
         ST_TLEN: begin
            cmd.rd_addr = pos_ff[7:0];
            if (k_ff == 3'd0) begin
               k_in = 3'd1;
            end else begin
               cmd.cap_tlen = 1'b1;
               cmd.clr_word = 1'b1;
               pos_in = pos_ff + 9'd1;
               k_in = '0;
               state_in = ST_TVAL;
            end
         end
         ST_TVAL: begin
            // gather up to four value bytes, skip the rest
            if (pos_ff + {1'b0, sts.tlv_len} > {1'b0, sts.held_length}) begin
               state_in = ST_APPLY;
            end else begin
               if (pend_ff) begin
                  cmd.cap_byte = 1'b1;
                  cmd.cap_slot = 2'(k_ff - 3'd1);
               end
               if (k_ff < 3'd4 && {5'd0, k_ff} < sts.tlv_len) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = 8'(pos_ff + 9'(k_ff));
                  pend_in = 1'b1;
                  k_in = k_ff + 3'd1;
               end else if (!pend_ff) begin
                  cmd.apply_tlv = 1'b1;
                  pos_in = pos_ff + {1'b0, sts.tlv_len};
                  k_in = '0;
                  state_in = ST_TAG;
               end
            end
         end
         ST_APPLY: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         k_ff     <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         k_ff     <= k_in;
         pend_ff  <= pend_in;
      end
   end

   // no request is taken while a result waits or dispatch runs
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !in_ready)
      else $error("request accepted while reply pending");
   // a result appears only right after the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid) |-> $past(cmd.finish))
      else $error("reply without finish");
   // the walk never passes the frame end
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TLEN) |-> (pos_ff < 9'(sts.held_length) + 9'd1))
      else $error("tlv walk past payload end");
endmodule

[sim/framed_command_receiver_top_test.sv]
// ----------------------------------------------------------------------------
// framed_command_receiver_top_test: self-checking bench for the frame receiver
// Streams framed commands and noise into the receiver, predicts every reply
// from a behavioral copy of the parser and dispatcher, and compares each
// reply field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_command_receiver_top_test;
   import fcr_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 400;
   localparam int RANDOM_BYTES = 1750;
   localparam int TAIL_BYTES = 300;

   typedef enum logic [2:0] {
      PARSE_IDLE, PARSE_TYPE, PARSE_SEQ, PARSE_LEN, PARSE_PAYLOAD, PARSE_CHECK
   } parse_t;

   // reply word, most significant field first
   typedef struct packed {
      logic        pad;
      logic        loop_en;
      logic [31:0] igain;
      logic [31:0] pgain;
      logic [15:0] tele;
      logic [15:0] heart;
      logic        hs_done;
      logic [31:0] flow_val;
      logic [1:0]  flow_req;
      logic        ok;
      logic [7:0]  ftype;
      logic [7:0]  seq;
      logic [1:0]  kind;
   } reply_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   // receiver model state
   parse_t      rx_phase;
   logic [7:0]  rx_type, rx_seq, rx_len, rx_count;
   logic [7:0]  rx_store [MAX_PAYLOAD];
   logic [15:0] live_heart, live_tele;
   logic        live_ack;
   logic [31:0] live_pgain, live_igain;
   logic        live_pien;

   reply_t pending_replies[$];
   int     error_count;
   int     idle_cycles;
   int     bytes_sent;
   bit     calm;

   framed_command_receiver_top i_dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [31:0] store_le(input int at, input int nbytes);
      logic [31:0] v;
      v = '0;
      for (int k = 0; k < nbytes; k++) v[8*k +: 8] = rx_store[at + k];
      return v;
   endfunction

   // dispatch a complete frame at its check byte
   function automatic void close_frame(input logic [7:0] chk, input logic room);
      reply_t r;
      logic [7:0] x;
      int pos, tlen;
      logic [7:0] tag;
      r = '0;
      x = rx_type ^ rx_seq;
      for (int k = 0; k < rx_len; k++) x ^= rx_store[k];
      if (x == chk) begin
         r.ok = 1'b1;
         if (rx_type == TYPE_HANDSHK) begin
            if (rx_len >= 5) begin
               live_heart = 16'(store_le(0, 2));
               live_tele  = 16'(store_le(2, 2));
               live_ack   = (rx_store[4] != 0);
               r.kind = REPLY_HACK;
               r.hs_done = 1'b1;
            end else if (live_ack) r.kind = REPLY_NACK;
         end else if (rx_type == TYPE_CONFIG) begin
            pos = 0;
            while (pos + 2 <= rx_len) begin
               tag  = rx_store[pos];
               tlen = int'(rx_store[pos + 1]);
               pos += 2;
               if (pos + tlen > rx_len) break;
               if (tag == TAG_TELEM && tlen == 2) live_tele = 16'(store_le(pos, 2));
               else if (tag == TAG_HEART && tlen == 2) live_heart = 16'(store_le(pos, 2));
               else if (tag == TAG_PGAIN && tlen == 4) live_pgain = store_le(pos, 4);
               else if (tag == TAG_IGAIN && tlen == 4) live_igain = store_le(pos, 4);
               else if (tag == TAG_PIEN && tlen == 1) live_pien = (rx_store[pos] != 0);
               pos += tlen;
            end
            if (live_ack) r.kind = REPLY_ACK;
         end else if (rx_type == TYPE_FLOW_Q || rx_type == TYPE_FLOW_I) begin
            if (rx_len >= 4) begin
               r.flow_val = store_le(0, 4);
               if (rx_type == TYPE_FLOW_Q) begin
                  r.flow_req = FLOW_QUEUED;
                  if (live_ack) r.kind = room ? REPLY_ACK : REPLY_NACK;
               end else begin
                  r.flow_req = FLOW_IMMED;
                  if (live_ack) r.kind = REPLY_ACK;
               end
            end else if (live_ack) r.kind = REPLY_NACK;
         end else if (live_ack) r.kind = REPLY_NACK;
      end else if (live_ack) r.kind = REPLY_NACK;
      rx_phase = PARSE_IDLE;
      rx_len   = '0;
      rx_count = '0;
      r.seq     = rx_seq;
      r.ftype   = rx_type;
      r.heart   = live_heart;
      r.tele    = live_tele;
      r.pgain   = live_pgain;
      r.igain   = live_igain;
      r.loop_en = live_pien;
      pending_replies.push_back(r);
   endfunction

   // advance the parser model by one accepted byte
   function automatic void absorb_byte(input logic [7:0] b, input logic room);
      case (rx_phase)
         PARSE_IDLE: if (b == SYNC_BYTE) rx_phase = PARSE_TYPE;
         PARSE_TYPE: begin
            rx_type  = b;
            rx_phase = PARSE_SEQ;
         end
         PARSE_SEQ: begin
            rx_seq   = b;
            rx_phase = PARSE_LEN;
         end
         PARSE_LEN: begin
            rx_len   = b;
            rx_count = '0;
            if (b == 0) rx_phase = PARSE_CHECK;
            else if (b <= MAX_PAYLOAD) rx_phase = PARSE_PAYLOAD;
            else rx_phase = PARSE_IDLE;
         end
         PARSE_PAYLOAD: begin
            if (rx_count < MAX_PAYLOAD) rx_store[rx_count[ADDR_W-1:0]] = b;
            rx_count = rx_count + 8'd1;
            if (rx_count >= rx_len) rx_phase = PARSE_CHECK;
         end
         PARSE_CHECK: close_frame(b, room);
         default: rx_phase = PARSE_IDLE;
      endcase
   endfunction

   // send one request byte; returns at a falling edge with valid still high
   task automatic send_byte(input logic [7:0] b, input logic room);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tdata  = b;
      req_tuser  = room;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      absorb_byte(b, room);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] seq,
                             input logic [7:0] pl[$], input bit corrupt,
                             input logic room);
      logic [7:0] x;
      x = ftype ^ seq;
      foreach (pl[k]) x ^= pl[k];
      if (corrupt) x ^= 8'(1 << $urandom_range(0, 7));
      send_byte(SYNC_BYTE, 1'($urandom_range(0, 1)));
      send_byte(ftype, 1'($urandom_range(0, 1)));
      send_byte(seq, 1'($urandom_range(0, 1)));
      send_byte(8'(pl.size()), 1'($urandom_range(0, 1)));
      foreach (pl[k]) send_byte(pl[k], 1'($urandom_range(0, 1)));
      send_byte(x, room);
   endtask

   // drain replies, let any walk finish, then write one register
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      req_tvalid = 1'b0;
      wait (pending_replies.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_index = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(posedge clock);
      case (idx)
         CSR_HEART: live_heart = val;
         CSR_TELEM: live_tele  = val;
         CSR_ACK:   live_ack   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic void add_tlv(ref logic [7:0] pl[$], input logic [7:0] tag,
                                   input int tlen);
      pl.push_back(tag);
      pl.push_back(8'(tlen));
      repeat (tlen) pl.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // compare each reply with the oldest prediction
   always @(posedge clock) begin
      reply_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, got %0h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("reply_kind", 32'(want.kind), 32'(got.kind));
            check_field("reply_seq", 32'(want.seq), 32'(got.seq));
            check_field("frame_type", 32'(want.ftype), 32'(got.ftype));
            check_field("check_ok", 32'(want.ok), 32'(got.ok));
            check_field("flow_request", 32'(want.flow_req), 32'(got.flow_req));
            check_field("flow_value", want.flow_val, got.flow_val);
            check_field("handshake_done", 32'(want.hs_done), 32'(got.hs_done));
            check_field("heartbeat_period", 32'(want.heart), 32'(got.heart));
            check_field("telemetry_period", 32'(want.tele), 32'(got.tele));
            check_field("prop_gain_bits", want.pgain, got.pgain);
            check_field("integral_gain_bits", want.igain, got.igain);
            check_field("loop_enable", 32'(want.loop_en), 32'(got.loop_en));
         end
      end
   end

   // stall the reply side in bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      logic [7:0] pl[$];
      pl = '{8'hE8, 8'h03, 8'h64, 8'h00, 8'h01};
      send_frame(TYPE_HANDSHK, 8'h00, pl, 0, 1);
      pl = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(TYPE_HANDSHK, 8'hFF, pl, 0, 1);              // short handshake
      send_frame(TYPE_FLOW_Q, 8'h01, pl, 0, 1);                // queued, room
      send_frame(TYPE_FLOW_Q, 8'h02, pl, 0, 0);                // queued, no room
      send_frame(TYPE_FLOW_I, 8'h03, pl, 0, 0);                // immediate
      pl = '{8'h12, 8'h34, 8'h56};
      send_frame(TYPE_FLOW_I, 8'h04, pl, 0, 1);                // short flow
      pl = '{};
      send_frame(8'h00, 8'h05, pl, 0, 1);                      // zero length
      send_frame(8'hFF, 8'h06, pl, 1, 1);                      // mismatch
      // every tag with its proper length, then two skipped tags and a lone byte
      add_tlv(pl, TAG_TELEM, 2);
      add_tlv(pl, TAG_HEART, 2);
      add_tlv(pl, TAG_PGAIN, 4);
      add_tlv(pl, TAG_IGAIN, 4);
      add_tlv(pl, TAG_PIEN, 1);
      add_tlv(pl, TAG_PGAIN, 3);
      add_tlv(pl, 8'h07, 2);
      pl.push_back(TAG_TELEM);
      send_frame(TYPE_CONFIG, 8'h07, pl, 0, 1);
      // entry running past the payload end
      pl = '{TAG_PIEN, 8'h01, 8'h00, TAG_TELEM, 8'h09, 8'h11};
      send_frame(TYPE_CONFIG, 8'h08, pl, 0, 1);
      // overlong length drops the frame
      send_byte(SYNC_BYTE, 1);
      send_byte(TYPE_FLOW_I, 1);
      send_byte(8'h09, 1);
      send_byte(8'(MAX_PAYLOAD + 1), 1);
      send_byte(SYNC_BYTE, 1);
      send_byte(TYPE_FLOW_I, 1);
      send_byte(8'h0A, 1);
      send_byte(8'hFF, 1);
      // full payload
      pl = '{};
      repeat (MAX_PAYLOAD) pl.push_back(8'($urandom_range(0, 255)));
      send_frame(TYPE_FLOW_Q, 8'h0B, pl, 0, 1);
      // handshake that turns acks off, then silent refusals
      pl = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
      send_frame(TYPE_HANDSHK, 8'h0C, pl, 0, 1);
      send_frame(8'h55, 8'h0D, pl, 0, 1);
      send_frame(TYPE_HANDSHK, 8'h0E, pl, 1, 1);
      pl = '{8'hAA, 8'h55, 8'hAA, 8'h55};
      send_frame(TYPE_FLOW_Q, 8'h0F, pl, 0, 0);
   endtask

   task automatic test_registers();
      write_reg(CSR_HEART, 16'hFFFF);
      write_reg(CSR_TELEM, 16'h0000);
      write_reg(CSR_ACK, 16'h0000);
      test_random(40);
      write_reg(CSR_HEART, 16'h0000);
      write_reg(CSR_TELEM, 16'hFFFF);
      write_reg(CSR_ACK, 16'hFFFF);
      test_random(40);
   endtask

   task automatic test_random(input int nframes);
      logic [7:0] pl[$];
      logic [7:0] ftype;
      int sel, plen;
      repeat (nframes) begin
         pl = '{};
         sel = $urandom_range(0, 19);
         ftype = (sel < 4) ? TYPE_HANDSHK : (sel < 9) ? TYPE_CONFIG :
                 (sel < 13) ? TYPE_FLOW_Q : (sel < 17) ? TYPE_FLOW_I :
                 8'($urandom_range(0, 255));
         if (ftype == TYPE_CONFIG) begin
            repeat ($urandom_range(0, 6)) begin
               sel = $urandom_range(1, 7);
               add_tlv(pl, 8'(sel), (sel == 1 || sel == 2) ? 2 :
                                    (sel == 3 || sel == 4) ? 4 :
                                    (sel == 5) ? 1 : $urandom_range(0, 5));
            end
            if ($urandom_range(0, 5) == 0) pl.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0 && pl.size() > 0) pl.pop_back();
         end else begin
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, MAX_PAYLOAD) :
                   $urandom_range(0, 8);
            repeat (plen) pl.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 24) == 0) begin
            // header with an oversize length, which the receiver drops
            send_byte(SYNC_BYTE, 1);
            send_byte(ftype, 0);
            send_byte(8'($urandom_range(0, 255)), 1);
            send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)), 0);
         end
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)),
                                                    1'($urandom_range(0, 1)));
         send_frame(ftype, 8'($urandom_range(0, 255)), pl, $urandom_range(0, 9) == 0,
                    1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_calm_tail();
      calm = 1'b1;
      test_random(5);
      while (bytes_sent < RANDOM_BYTES) test_random(5);
   endtask

   initial begin
      calm        = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      bytes_sent  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_HEART;
      csr_wdata   = '0;
      rx_phase    = PARSE_IDLE;
      rx_type     = '0;
      rx_seq      = '0;
      rx_len      = '0;
      rx_count    = '0;
      live_heart  = 16'd1000;
      live_tele   = 16'd100;
      live_ack    = 1'b1;
      live_pgain  = '0;
      live_igain  = '0;
      live_pien   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_registers();
      write_reg(CSR_HEART, 16'($urandom_range(0, 65535)));
      write_reg(CSR_TELEM, 16'($urandom_range(0, 65535)));
      write_reg(CSR_ACK, 16'h0001);
      while (bytes_sent < RANDOM_BYTES - TAIL_BYTES) test_random(10);
      test_calm_tail();

      req_tvalid = 1'b0;
      wait (pending_replies.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
